// ===== design/msq_pkg.sv =====
// ----------------------------------------------------------------------------
// msq_pkg: shared types, constants and microprogram
// Control word layout, step addresses, status flags and the microcode ROM
// of the minimum square-sum counter.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

  localparam int QUERY_W = 14;
  localparam int COUNT_W = 3;
  localparam int STEP_W  = 4;

  localparam logic [COUNT_W-1:0] ERR_CODE  = 3'd7;
  localparam logic [COUNT_W-1:0] BEST_INIT = 3'd7;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram addresses
  localparam step_t S_IDLE      = 4'd0;
  localparam step_t S_CHK_RANGE = 4'd1;
  localparam step_t S_CHK_FILL  = 4'd2;
  localparam step_t S_INIT      = 4'd3;
  localparam step_t S_SCAN      = 4'd4;
  localparam step_t S_WRITE     = 4'd5;
  localparam step_t S_LOOKUP    = 4'd6;
  localparam step_t S_RESOLVE   = 4'd7;
  localparam step_t S_ERR       = 4'd8;
  localparam step_t S_DONE      = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_INIT,
    OP_SCAN,
    OP_WRITE,
    OP_LOOKUP,
    OP_RESOLVE,
    OP_ERR,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_OVER,
    COND_CACHED,
    COND_SQ_GT,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t t_true;
    step_t t_false;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic over;
    logic cached;
    logic sq_gt;
    logic out_free;
  } flags_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, t_true: S_IDLE, t_false: S_IDLE};
    unique case (step)
      S_IDLE:      w = '{OP_ACCEPT,  COND_IN_VALID, S_CHK_RANGE, S_IDLE};
      S_CHK_RANGE: w = '{OP_NOP,     COND_OVER,     S_ERR,       S_CHK_FILL};
      S_CHK_FILL:  w = '{OP_NOP,     COND_CACHED,   S_LOOKUP,    S_INIT};
      S_INIT:      w = '{OP_INIT,    COND_ALWAYS,   S_SCAN,      S_SCAN};
      S_SCAN:      w = '{OP_SCAN,    COND_SQ_GT,    S_WRITE,     S_SCAN};
      S_WRITE:     w = '{OP_WRITE,   COND_ALWAYS,   S_CHK_FILL,  S_CHK_FILL};
      S_LOOKUP:    w = '{OP_LOOKUP,  COND_ALWAYS,   S_RESOLVE,   S_RESOLVE};
      S_RESOLVE:   w = '{OP_RESOLVE, COND_ALWAYS,   S_DONE,      S_DONE};
      S_ERR:       w = '{OP_ERR,     COND_ALWAYS,   S_DONE,      S_DONE};
      S_DONE:      w = '{OP_EMIT,    COND_OUT_FREE, S_IDLE,      S_DONE};
      default:     w = '{OP_NOP,     COND_ALWAYS,   S_IDLE,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/msq_ram.sv =====
// ----------------------------------------------------------------------------
// msq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/msq_seq.sv =====
// ----------------------------------------------------------------------------
// msq_seq: microcode sequencer
// Step counter and control ROM; picks the next step from the datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire msq_pkg::flags_t flags,
  output      msq_pkg::ucode_t ctrl
);

  msq_pkg::step_t step;
  msq_pkg::step_t step_next;
  logic           taken;

  assign ctrl = msq_pkg::ucode_rom(step);

  always_comb begin
    unique case (ctrl.cond)
      msq_pkg::COND_ALWAYS:   taken = 1'b1;
      msq_pkg::COND_IN_VALID: taken = flags.in_valid;
      msq_pkg::COND_OVER:     taken = flags.over;
      msq_pkg::COND_CACHED:   taken = flags.cached;
      msq_pkg::COND_SQ_GT:    taken = flags.sq_gt;
      msq_pkg::COND_OUT_FREE: taken = flags.out_free;
      default:                taken = 1'b1;
    endcase
    step_next = taken ? ctrl.t_true : ctrl.t_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= msq_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/msq_dp.sv =====
// ----------------------------------------------------------------------------
// msq_dp: table datapath
// Query and scan registers, the count table RAM, the running minimum and
// the output register, all steered by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_dp #(
  parameter int TABLE_DEPTH = 16384
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire msq_pkg::ucode_t               ctrl,
  output      msq_pkg::flags_t               flags,
  input  wire logic                          in_valid,
  input  wire logic [msq_pkg::QUERY_W-1:0]   query_value,
  input  wire logic                          out_ready,
  output      logic                          out_valid,
  output      logic [msq_pkg::COUNT_W-1:0]   square_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int SQ_W  = IDX_W + 1;
  localparam int X_W   = (IDX_W + 1) / 2 + 1;
  localparam int CW    = (IDX_W + 1 > msq_pkg::QUERY_W + 1) ? IDX_W + 1
                                                            : msq_pkg::QUERY_W + 1;

  logic [msq_pkg::QUERY_W-1:0] n;
  logic [IDX_W-1:0]            filled;
  logic [IDX_W-1:0]            i;
  logic [X_W-1:0]              x;
  logic [SQ_W-1:0]             sq;
  logic [msq_pkg::COUNT_W-1:0] best;
  logic                        pend;
  logic                        rd_byp;
  logic [1:0]                  byp_val;
  logic [msq_pkg::COUNT_W-1:0] result;

  logic                        ram_we;
  logic                        ram_re;
  logic [IDX_W-1:0]            ram_raddr;
  logic [msq_pkg::COUNT_W-1:0] ram_rdata;

  logic [IDX_W-1:0]            scan_addr;
  logic [msq_pkg::COUNT_W-1:0] rd_val;
  logic [msq_pkg::COUNT_W-1:0] cand;
  logic [msq_pkg::COUNT_W-1:0] best_min;
  logic                        raddr_small;
  logic                        out_free;

  assign scan_addr = i - IDX_W'(sq);
  assign rd_val    = rd_byp ? {1'b0, byp_val} : ram_rdata;
  assign cand      = rd_val + msq_pkg::COUNT_W'(1);
  assign best_min  = (pend && (cand < best)) ? cand : best;
  assign out_free  = !out_valid || out_ready;

  // Entries 0..3 are never stored; they read back as their own index.
  assign raddr_small = CW'(ram_raddr) < CW'(4);

  assign flags.in_valid = in_valid;
  assign flags.over     = CW'(n) >= CW'(TABLE_DEPTH);
  assign flags.cached   = CW'(filled) >= CW'(n);
  assign flags.sq_gt    = sq > SQ_W'(i);
  assign flags.out_free = out_free;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = scan_addr;
    ram_we    = 1'b0;
    unique case (ctrl.op)
      msq_pkg::OP_SCAN: begin
        ram_re = !flags.sq_gt;
      end
      msq_pkg::OP_LOOKUP: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(n);
      end
      msq_pkg::OP_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  msq_ram #(
    .WIDTH (msq_pkg::COUNT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (i),
    .wdata (best),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= IDX_W'(3);
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken.
      if (ctrl.op == msq_pkg::OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (ctrl.op)
        msq_pkg::OP_ACCEPT: begin
          if (in_valid) begin
            n <= query_value;
          end
        end
        msq_pkg::OP_INIT: begin
          i    <= filled + IDX_W'(1);
          x    <= X_W'(1);
          sq   <= SQ_W'(1);
          best <= msq_pkg::BEST_INIT;
          pend <= 1'b0;
        end
        msq_pkg::OP_SCAN: begin
          // Fold in last cycle's read, issue the next one while x*x <= i.
          best <= best_min;
          if (!flags.sq_gt) begin
            pend    <= 1'b1;
            rd_byp  <= raddr_small;
            byp_val <= ram_raddr[1:0];
            x       <= x + X_W'(1);
            sq      <= sq + SQ_W'({x, 1'b1});
          end else begin
            pend <= 1'b0;
          end
        end
        msq_pkg::OP_WRITE: begin
          filled <= i;
        end
        msq_pkg::OP_LOOKUP: begin
          rd_byp  <= raddr_small;
          byp_val <= ram_raddr[1:0];
        end
        msq_pkg::OP_RESOLVE: begin
          result <= rd_val;
        end
        msq_pkg::OP_ERR: begin
          result <= msq_pkg::ERR_CODE;
        end
        msq_pkg::OP_EMIT: begin
          if (out_free) begin
            square_count <= result;
          end
        end
        default: begin
          pend <= pend;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/min_squares_sum_count.sv =====
// ----------------------------------------------------------------------------
// min_squares_sum_count: least number of perfect squares summing to a query
// Microcoded sequencer over a cached bottom-up count table in RAM.
// ----------------------------------------------------------------------------
//  channel  handshake             payload          width
//  input    in_valid / in_ready   query_value      14, unsigned
//  output   out_valid / out_ready square_count     3, unsigned
//
//  A cached query (at or below the highest filled entry) steps through the
//  range check, fill check, table lookup and resolve steps to its result, then
//  returns to idle once the output is free. Each new entry i takes setup,
//  floor(sqrt(i)) table reads, one per candidate square through the single
//  RAM read port, the final compare, write-back and the fill check. One query
//  is in work at a time.
//  Reset leaves entries 0..3 answered from constants; no clearing pass.
//  A stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module min_squares_sum_count #(
  parameter int TABLE_DEPTH = 16384
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [msq_pkg::QUERY_W-1:0] query_value,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [msq_pkg::COUNT_W-1:0] square_count
);

  msq_pkg::ucode_t ctrl;
  msq_pkg::flags_t flags;

  assign in_ready = (ctrl.op == msq_pkg::OP_ACCEPT);

  msq_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  msq_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .flags        (flags),
    .in_valid     (in_valid),
    .query_value  (query_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .square_count (square_count)
  );

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (square_count <= 3'd4 || square_count == msq_pkg::ERR_CODE))
    else $error("square_count out of range");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer stayed idle after a transaction");

  a_emit: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == msq_pkg::OP_EMIT && flags.out_free) |=> (out_valid && in_ready))
    else $error("result not presented after emit");
`endif

endmodule

`default_nettype wire
